// File: rtl/pfi_pkg.sv
// Package for the particle force integrator: command codes, widths, reset values.
// Used by pfi_axis and particle_force_integrator_top.
package pfi_pkg;
	localparam int unsigned ParticlesDefault = 64;
	localparam logic [30:0] MaxForceReset = 31'h7FFF_FFFF;
	localparam logic [15:0] StepTimeReset = 16'd1092;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_INTG = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_MAX_FORCE = 1'b0,
		CFG_STEP_TIME = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_WB, ST_OUT
	} state_t;

	// Per-axis stored state of one particle.
	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic signed [31:0] frc;
	} axis_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -66'sh0_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// round(x / 2^s): add half LSB, arithmetic shift
	function automatic logic signed [65:0] rnd(input logic signed [65:0] x, input int s);
		logic signed [65:0] h;
		h = 66'sd1 <<< (s - 1);
		return (x + h) >>> s;
	endfunction
endpackage

// File: rtl/pfi_axis.sv
// Per-axis integrate datapath of the particle force integrator.
// Sequenced by the top level, one multiply per step; uses pfi_pkg.
module pfi_axis (
	input  logic                 clk,
	input  logic [2:0]           step,
	input  pfi_pkg::axis_t       st,
	input  logic [31:0]          imass,
	input  logic [16:0]          drag,
	input  logic [15:0]          dt,
	input  logic [30:0]          lim,
	output pfi_pkg::axis_t       res
);
	import pfi_pkg::*;

	logic signed [31:0] v1_q, a_q, np_q, nv_q;
	logic signed [65:0] prod_q, ad_q;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [31:0] f;
	logic [31:0] dt2_q;

	// step 0 vel*drag, 1 f*imass, 2 acc*dt^2, 3 v1*dt, 4 a*dt; each product is registered
	always_comb begin
		f = st.frc;
		if (st.frc > $signed({1'b0, lim})) f = $signed({1'b0, lim});
		if (st.frc < -$signed({1'b0, lim})) f = -$signed({1'b0, lim});
		mul_a = '0;
		mul_b = '0;
		case (step)
			3'd0: begin mul_a = 33'(st.vel); mul_b = {16'd0, drag}; end
			3'd1: begin mul_a = 33'(f); mul_b = {1'b0, imass}; end
			3'd2: begin mul_a = 33'(st.acc); mul_b = {1'b0, dt2_q}; end
			3'd3: begin mul_a = 33'(v1_q); mul_b = {17'd0, dt}; end
			3'd4: begin mul_a = 33'(a_q); mul_b = {17'd0, dt}; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		dt2_q <= 32'(dt) * 32'(dt);
		prod_q <= 66'(mul_a) * 66'(mul_b);
		case (step)
			3'd1: v1_q <= sat32(rnd(prod_q, 16));
			3'd2: a_q <= sat32(rnd(prod_q, 16));
			3'd3: ad_q <= rnd(prod_q, 17);
			3'd4: np_q <= sat32(66'(st.pos) + rnd(prod_q + ad_q, 16));
			3'd5: nv_q <= sat32(66'(v1_q) + rnd(prod_q, 16));
			default: ;
		endcase
	end

	assign res.pos = np_q;
	assign res.vel = nv_q;
	assign res.acc = a_q;
	assign res.frc = '0;
endmodule

// File: rtl/particle_force_integrator_top.sv
// Top level of the particle force integrator: memories, sequencer, ports.
// Depends on pfi_pkg and pfi_axis.
//
// Usage: commands arrive on the in channel (in_valid/in_ready); each gives one
// beat on the out channel (out_valid/out_ready) with the entry's position and
// velocity after the command. Configuration writes (cfg_we, cfg_index,
// cfg_data_lo) are taken at any edge and must only happen while idle.
// One command at a time: read of the particle memories (ST_RD), then for
// integrate a 6-step multiply sequence (ST_M1 to ST_M6) in the shared
// per-axis units, then write-back (ST_WB); out_valid rises in ST_OUT, after
// write-back, for every command. in_ready returns the cycle after the result
// beat is taken, so the block takes no new command before the last is through.
// The result sits in an output register; a stalled receiver holds it and the
// block takes no new command until it is taken.
// Reset idles control and loads configuration defaults; memory is undefined
// until an entry is loaded. Indexes beyond the table return all-zero results.
module particle_force_integrator_top #(
	parameter int unsigned PARTICLES = pfi_pkg::ParticlesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [30:0]        cfg_data_lo,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [5:0]         particle_index,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic [31:0]        inverse_mass_in,
	input  logic [16:0]        drag_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z
);
	import pfi_pkg::*;
	localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	state_t state_q, state_d;
	logic [30:0] max_force_q;
	logic [15:0] step_time_q;
	logic [2:0] step_q;
	cmd_t cmd_q;
	logic [AW-1:0] idx_q;
	logic oor_q;
	logic signed [31:0] vec_q [3];
	logic [31:0] im_in_q;
	logic [16:0] dg_in_q;

	axis_t mem [3][PARTICLES];
	logic [31:0] im_mem [PARTICLES];
	logic [16:0] dg_mem [PARTICLES];
	axis_t rd_s1 [3];
	logic [31:0] im_s1;
	logic [16:0] dg_s1;
	axis_t res [3];
	logic signed [31:0] opos_q [3], ovel_q [3];
	logic wr_en;
	axis_t wr_d [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_force_q <= MaxForceReset;
			step_time_q <= StepTimeReset;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_FORCE: max_force_q <= cfg_data_lo;
				CFG_STEP_TIME: step_time_q <= cfg_data_lo[15:0];
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_t'(cmd);
			idx_q <= AW'(particle_index);
			oor_q <= 32'(particle_index) >= PARTICLES;
			vec_q[0] <= vec_x;
			vec_q[1] <= vec_y;
			vec_q[2] <= vec_z;
			im_in_q <= inverse_mass_in;
			dg_in_q <= drag_in;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) rd_s1[k] <= mem[k][idx_q];
		im_s1 <= im_mem[idx_q];
		dg_s1 <= dg_mem[idx_q];
	end

	for (genvar k = 0; k < 3; k++) begin : g_ax
		pfi_axis u_axis (
			.clk(clk), .step(step_q), .st(rd_s1[k]), .imass(im_s1), .drag(dg_s1),
			.dt(step_time_q), .lim(max_force_q), .res(res[k])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wr_d[k] = rd_s1[k];
			case (cmd_q)
				CMD_LOAD: wr_d[k] = '{pos: vec_q[k], vel: '0, acc: '0, frc: '0};
				CMD_ADD:  wr_d[k].frc = sat32(66'(rd_s1[k].frc) + 66'(vec_q[k]));
				CMD_INTG: wr_d[k] = res[k];
				default: ;
			endcase
		end
	end

	assign wr_en = (state_q == ST_WB) && !oor_q && (cmd_q != CMD_NOP);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < 3; k++) mem[k][idx_q] <= wr_d[k];
			if (cmd_q == CMD_LOAD) begin
				im_mem[idx_q] <= im_in_q;
				dg_mem[idx_q] <= dg_in_q;
			end
		end
		if (state_q == ST_WB) begin
			for (int k = 0; k < 3; k++) begin
				opos_q[k] <= oor_q ? '0 : wr_d[k].pos;
				ovel_q[k] <= oor_q ? '0 : wr_d[k].vel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= (state_q == ST_RD || state_q == ST_IDLE) ? 3'd0 : step_q + 3'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RD;
			ST_RD:   state_d = (cmd_q == CMD_INTG) ? ST_M1 : ST_WB;
			ST_M1:   state_d = ST_M2;
			ST_M2:   state_d = ST_M3;
			ST_M3:   state_d = ST_M4;
			ST_M4:   state_d = ST_M5;
			ST_M5:   state_d = ST_M6;
			ST_M6:   state_d = ST_WB;
			ST_WB:   state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);
	assign pos_x = opos_q[0];
	assign pos_y = opos_q[1];
	assign pos_z = opos_q[2];
	assign vel_x = ovel_q[0];
	assign vel_y = ovel_q[1];
	assign vel_z = ovel_q[2];

	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en) else $error("write while idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_one_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("overlap");
endmodule

// File: tb/particle_force_integrator_top_tb.sv
// Testbench for particle_force_integrator_top: directed command table, then random
// load/add/integrate/nop traffic checked against an in-bench integrator model.
// Depends on pfi_pkg and the RTL of the particle force integrator.
`timescale 1ns / 100ps

module particle_force_integrator_top_tb;
	import pfi_pkg::*;

	typedef struct {
		cmd_t        op;
		logic [5:0]  idx;
		logic [31:0] vx, vy, vz;
		logic [31:0] imass;
		logic [16:0] drag;
	} command_t;

	typedef struct {
		logic [31:0] p [3];
		logic [31:0] v [3];
	} state_rpt_t;

	typedef struct {
		command_t   c;
		bit         fixed;
		state_rpt_t r;
	} row_t;

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [30:0] cfg_data_lo;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] cmd;
	logic [5:0] particle_index;
	logic signed [31:0] vec_x, vec_y, vec_z;
	logic [31:0] inverse_mass_in;
	logic [16:0] drag_in;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;

	particle_force_integrator_top dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// model state
	logic [30:0] force_limit;
	logic [15:0] dt_q16;
	logic signed [31:0] m_pos [192], m_vel [192], m_acc [192], m_frc [192];
	logic [31:0] m_imass [64];
	logic [16:0] m_drag [64];
	bit loaded [64];

	state_rpt_t expected_states [$];
	int errors;
	longint cycles;

	function automatic longint sat_q(longint x);
		if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (x < -64'sh8000_0000) return -64'sh8000_0000;
		return x;
	endfunction

	function automatic longint round_sh(longint x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	task automatic integrate_model(command_t c, output state_rpt_t r);
		int e;
		longint v1, disp, f, a, dt, lim;
		dt = dt_q16;
		lim = force_limit;
		for (int k = 0; k < 3; k++) begin
			e = c.idx * 3 + k;
			case (c.op)
				CMD_LOAD: begin
					m_pos[e] = (k == 0) ? c.vx : (k == 1) ? c.vy : c.vz;
					m_vel[e] = 0; m_acc[e] = 0; m_frc[e] = 0;
				end
				CMD_ADD: begin
					m_frc[e] = 32'(sat_q(longint'(m_frc[e]) +
						longint'(signed'((k == 0) ? c.vx : (k == 1) ? c.vy : c.vz))));
				end
				CMD_INTG: begin
					v1 = sat_q(round_sh(longint'(m_vel[e]) * longint'(m_drag[c.idx]), 16));
					disp = v1 * dt + round_sh(longint'(m_acc[e]) * dt * dt, 17);
					m_pos[e] = 32'(sat_q(longint'(m_pos[e]) + round_sh(disp, 16)));
					f = m_frc[e];
					if (f > lim) f = lim;
					if (f < -lim) f = -lim;
					a = sat_q(round_sh(longint'(m_imass[c.idx]) * f, 16));
					m_acc[e] = 32'(a);
					m_vel[e] = 32'(sat_q(v1 + round_sh(a * dt, 16)));
					m_frc[e] = 0;
				end
				default: ;
			endcase
			r.p[k] = m_pos[e];
			r.v[k] = m_vel[e];
		end
		if (c.op == CMD_LOAD) begin
			m_imass[c.idx] = c.imass;
			m_drag[c.idx] = c.drag;
			loaded[c.idx] = 1'b1;
		end
	endtask

	task automatic report(string msg);
		errors++;
		$display("%0t mismatch %s", $time, msg);
	endtask

	// receiver: stall pattern, compare on accepted beat
	int stall_phase;
	always @(posedge clk) begin
		state_rpt_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_states.size() == 0) begin
				report("unexpected result beat");
			end else begin
				w = expected_states.pop_front();
				if (pos_x !== w.p[0])
					report($sformatf("pos_x: got %h expected %h", pos_x, w.p[0]));
				if (pos_y !== w.p[1])
					report($sformatf("pos_y: got %h expected %h", pos_y, w.p[1]));
				if (pos_z !== w.p[2])
					report($sformatf("pos_z: got %h expected %h", pos_z, w.p[2]));
				if (vel_x !== w.v[0])
					report($sformatf("vel_x: got %h expected %h", vel_x, w.v[0]));
				if (vel_y !== w.v[1])
					report($sformatf("vel_y: got %h expected %h", vel_y, w.v[1]));
				if (vel_z !== w.v[2])
					report($sformatf("vel_z: got %h expected %h", vel_z, w.v[2]));
			end
		end
	end

	always @(negedge clk) begin
		stall_phase = (stall_phase + 1) % 64;
		if (stall_phase < 20) out_ready <= 1'b1;
		else if (stall_phase < 40) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= ($urandom_range(0, 1) != 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t i, logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= i; cfg_data_lo <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (i == CFG_MAX_FORCE) force_limit = val; else dt_q16 = val[15:0];
	endtask

	int gap_left, burst_left;

	// drive one beat; called at a falling edge, returns at a falling edge with valid
	// still high, so the next beat of a burst follows with no gap
	task automatic send(command_t c, bit fixed, state_rpt_t want);
		state_rpt_t r;
		bit bad;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				repeat (gap_left) @(negedge clk);
			end
		end
		burst_left--;
		integrate_model(c, r);
		if (fixed) begin
			bad = 1'b0;
			for (int k = 0; k < 3; k++)
				if (r.p[k] !== want.p[k] || r.v[k] !== want.v[k]) bad = 1'b1;
			if (bad) report("table row disagrees with model");
			r = want;
		end
		expected_states.insert(expected_states.size(), r);
		in_valid <= 1'b1;
		cmd <= c.op; particle_index <= c.idx;
		vec_x <= c.vx; vec_y <= c.vy; vec_z <= c.vz;
		inverse_mass_in <= c.imass; drag_in <= c.drag;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_states.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic command_t rand_cmd(bit load_only);
		command_t c;
		int pick;
		c.idx = 6'($urandom_range(0, 63));
		pick = $urandom_range(0, 9);
		if (load_only || !loaded[c.idx]) c.op = CMD_LOAD;
		else if (pick < 4) c.op = CMD_ADD;
		else if (pick < 8) c.op = CMD_INTG;
		else if (pick < 9) c.op = CMD_NOP;
		else c.op = CMD_LOAD;
		c.vx = rnd_val(); c.vy = rnd_val(); c.vz = rnd_val();
		c.imass = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0003_0000);
		c.drag = 17'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(60000, 65536));
		return c;
	endfunction

	row_t directed [$];

	task automatic add_row(cmd_t op, int idx, logic [31:0] x, y, z, m, logic [16:0] d,
			bit fixed, logic [31:0] px, py, pz, vx, vy, vz);
		row_t r;
		r.c.op = op; r.c.idx = 6'(idx);
		r.c.vx = x; r.c.vy = y; r.c.vz = z; r.c.imass = m; r.c.drag = d;
		r.fixed = fixed;
		r.r.p = '{px, py, pz};
		r.r.v = '{vx, vy, vz};
		directed.insert(directed.size(), r);
	endtask

	initial begin
		command_t c;
		state_rpt_t none;
		errors = 0; cycles = 0; stall_phase = 0; burst_left = 0;
		force_limit = MaxForceReset; dt_q16 = StepTimeReset;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = CFG_MAX_FORCE; cfg_data_lo = '0;
		in_valid = 1'b0; out_ready = 1'b0; cmd = CMD_NOP; particle_index = '0;
		vec_x = '0; vec_y = '0; vec_z = '0; inverse_mass_in = '0; drag_in = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, unused command, drag above one
		add_row(CMD_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 17'h1FFFF,
			1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
		add_row(CMD_LOAD, 63, 32'h0001_0000, 32'hFFFF_0000, 5, 32'h0001_0000, 17'd65536,
			1, 32'h0001_0000, 32'hFFFF_0000, 5, 0, 0, 0);
		add_row(CMD_ADD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_ADD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_INTG, 0, 0, 0, 0, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_INTG, 0, 0, 0, 0, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_NOP, 0, 32'hDEAD_BEEF, 1, 2, 3, 4, 0, 0,0,0,0,0,0);
		add_row(CMD_ADD, 63, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_INTG, 63, 0, 0, 0, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_INTG, 63, 0, 0, 0, 0, 0, 0, 0,0,0,0,0,0);
		add_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 1, 0,0,0,0,0,0);
		add_row(CMD_INTG, 0, 0, 0, 0, 0, 0, 1, 0,0,0,0,0,0);
		foreach (directed[i]) send(directed[i].c, directed[i].fixed, directed[i].r);
		drain();

		// settings: reset, extremes, zero clamp, odd steps
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_MAX_FORCE, 31'h7FFF_FFFF);
					write_reg(CFG_STEP_TIME, 31'd1); end
				1: begin write_reg(CFG_MAX_FORCE, 31'd0);
					write_reg(CFG_STEP_TIME, 31'h0000_FFFF); end
				2: begin write_reg(CFG_MAX_FORCE, 31'h0004_0000);
					write_reg(CFG_STEP_TIME, 31'd1092); end
				3: begin write_reg(CFG_MAX_FORCE, 31'($urandom));
					write_reg(CFG_STEP_TIME, 31'd0); end
				4: begin write_reg(CFG_MAX_FORCE, 31'($urandom));
					write_reg(CFG_STEP_TIME, 31'($urandom)); end
				default: begin write_reg(CFG_MAX_FORCE, MaxForceReset);
					write_reg(CFG_STEP_TIME, 31'(StepTimeReset)); end
			endcase
			for (int n = 0; n < 170; n++) begin
				c = rand_cmd(1'b0);
				send(c, 1'b0, none);
			end
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
